@@ hdl/lcdi_pkg.sv @@
// Shared types and constants for the display init list interpreter.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcdi_pkg;

   localparam logic [7:0]  LONG_MARK        = 8'hFF;
   localparam logic [15:0] LONG_DELAY_RESET = 16'd500;
   localparam int          DELAY_FLAG_BIT   = 7;

   typedef enum logic [1:0] {
      KIND_CMD  = 2'd0,
      KIND_DATA = 2'd1,
      KIND_WAIT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] list_byte;
      logic       list_start;
   } item_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] wait_ms;
      logic        done;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/lcdi_in_stage.sv @@
// Input register of the init list interpreter.
// Depends on lcdi_pkg for the item type.
`default_nettype none

module lcdi_in_stage (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire lcdi_pkg::item_type req_item,
   input  wire                 advance,
   output logic                item_valid,
   output lcdi_pkg::item_type  item
);
   import lcdi_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_ready  = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule

`default_nettype wire

@@ hdl/lcdi_parser.sv @@
// List parsing state machine and the long delay register.
// Depends on lcdi_pkg for item and result types.
`default_nettype none

module lcdi_parser (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_wr_en,
   input  wire [15:0]          csr_wr_data,
   input  wire                 step,
   input  wire lcdi_pkg::item_type item,
   output lcdi_pkg::result_type result
);
   import lcdi_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_CMD   = 3'd1,
      PH_ARGC  = 3'd2,
      PH_ARGS  = 3'd3,
      PH_DELAY = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  cmds_ff, cmds_in;
   logic [6:0]  args_ff, args_in;
   logic        pend_ff, pend_in;
   logic [15:0] long_ff;
   logic [6:0]  args_dec;
   phase_type   end_phase;

   assign args_dec  = args_ff - 7'd1;
   // where the entry closes: next command, or idle if none remain
   assign end_phase = (cmds_ff != 8'd0) ? PH_CMD : PH_IDLE;

   always_comb begin
      phase_in = phase_ff;
      cmds_in  = cmds_ff;
      args_in  = args_ff;
      pend_in  = pend_ff;
      result   = '0;
      if (step) begin
         if (item.list_start) begin
            cmds_in  = item.list_byte;
            args_in  = 7'd0;
            pend_in  = 1'b0;
            phase_in = (item.list_byte != 8'd0) ? PH_CMD : PH_IDLE;
         end else begin
            case (phase_ff)
               PH_CMD: begin
                  cmds_in      = cmds_ff - 8'd1;
                  phase_in     = PH_ARGC;
                  result.valid = 1'b1;
                  result.kind  = KIND_CMD;
                  result.data  = item.list_byte;
               end
               PH_ARGC: begin
                  args_in = item.list_byte[6:0];
                  pend_in = item.list_byte[DELAY_FLAG_BIT];
                  if (item.list_byte[6:0] != 7'd0) begin
                     phase_in = PH_ARGS;
                  end else if (item.list_byte[DELAY_FLAG_BIT]) begin
                     phase_in = PH_DELAY;
                  end else begin
                     pend_in  = 1'b0;
                     phase_in = end_phase;
                  end
               end
               PH_ARGS: begin
                  args_in      = args_dec;
                  result.valid = 1'b1;
                  result.kind  = KIND_DATA;
                  result.data  = item.list_byte;
                  if (args_dec == 7'd0) begin
                     if (pend_ff) begin
                        phase_in = PH_DELAY;
                     end else begin
                        phase_in    = end_phase;
                        result.done = (cmds_ff == 8'd0);
                     end
                  end
               end
               PH_DELAY: begin
                  args_in        = 7'd0;
                  pend_in        = 1'b0;
                  phase_in       = end_phase;
                  result.valid   = 1'b1;
                  result.kind    = KIND_WAIT;
                  result.wait_ms = (item.list_byte == LONG_MARK) ? long_ff
                                                                 : {8'd0, item.list_byte};
                  result.done    = (cmds_ff == 8'd0);
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmds_ff  <= 8'd0;
         args_ff  <= 7'd0;
         pend_ff  <= 1'b0;
         long_ff  <= LONG_DELAY_RESET;
      end else begin
         phase_ff <= phase_in;
         cmds_ff  <= cmds_in;
         args_ff  <= args_in;
         pend_ff  <= pend_in;
         if (csr_wr_en) begin
            long_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/lcdi_out_stage.sv @@
// Result register of the init list interpreter.
// Depends on lcdi_pkg for the result type.
`default_nettype none

module lcdi_out_stage (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  wire lcdi_pkg::result_type result,
   input  wire                   rsp_ready,
   output logic                  rsp_valid,
   output logic                  free,
   output lcdi_pkg::result_type  held
);
   import lcdi_pkg::*;

   logic       valid_ff, valid_in;
   result_type held_ff;

   assign rsp_valid = valid_ff;
   assign free      = !valid_ff || rsp_ready;
   assign held      = held_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = result.valid;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load && result.valid) begin
         held_ff <= result;
      end
   end

endmodule

`default_nettype wire

@@ hdl/lcd_init_command_list_interpreter.sv @@
// Top level of the display init list interpreter.
// Depends on lcdi_pkg, lcdi_in_stage, lcdi_parser and lcdi_out_stage.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_list_byte, req_list_start
//   rsp     | out       | rsp_valid/rsp_ready | rsp_out_kind, rsp_out_byte,
//           |           |                     | rsp_wait_ms, rsp_list_done
//   csr     | in        | csr_wr_en           | csr_wr_data (long delay, ms)
//
// One list byte per cycle unless a stalled result holds the input; each result passes
// through the input register and the result register around the parse step.
// Synchronous reset clears the parse state to idle and the long delay to 500.
// A stalled result holds the output; the parse step waits until the result
// register is free, and the input register keeps one byte meanwhile.
`default_nettype none

module lcd_init_command_list_interpreter (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [7:0]  req_list_byte,
   input  wire        req_list_start,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic [15:0] rsp_wait_ms,
   output logic       rsp_list_done,
   input  wire        csr_wr_en,
   input  wire [15:0] csr_wr_data
);
   import lcdi_pkg::*;

   item_type   req_item, item;
   logic       item_valid, out_free, advance;
   result_type result, held;

   assign req_item.list_byte  = req_list_byte;
   assign req_item.list_start = req_list_start;
   assign advance = item_valid && out_free;

   lcdi_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lcdi_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .item        (item),
      .result      (result)
   );

   lcdi_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .free      (out_free),
      .held      (held)
   );

   assign rsp_out_kind  = held.kind;
   assign rsp_out_byte  = held.data;
   assign rsp_wait_ms   = held.wait_ms;
   assign rsp_list_done = held.done;

endmodule

`default_nettype wire

@@ hdl/lcdi_checker.sv @@
// Port-level checks for the display init list interpreter, bound to the top.
// Depends on lcdi_pkg for the result kind codes.
`default_nettype none

module lcdi_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_out_kind,
   input wire [7:0]  rsp_out_byte,
   input wire [15:0] rsp_wait_ms,
   input wire        rsp_list_done
);
   import lcdi_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind)
         && $stable(rsp_out_byte) && $stable(rsp_wait_ms) && $stable(rsp_list_done))
      else $error("stalled result changed");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_kind == KIND_CMD || rsp_out_kind == KIND_DATA
         || rsp_out_kind == KIND_WAIT)
      else $error("result kind out of range");

   a_wait_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_WAIT |-> rsp_wait_ms == 16'd0)
      else $error("wait on a send result");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_WAIT |-> rsp_out_byte == 8'd0)
      else $error("byte on a wait result");

   a_cmd_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_CMD |-> !rsp_list_done)
      else $error("command byte ends the list");

endmodule

bind lcd_init_command_list_interpreter lcdi_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_kind  (rsp_out_kind),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_wait_ms   (rsp_wait_ms),
   .rsp_list_done (rsp_list_done)
);

`default_nettype wire

@@ sim/tb_lcd_init_command_list_interpreter.sv @@
// Self-checking testbench for the display init list interpreter.
// Drives list bytes and the long-delay register, predicts each result in place or takes it from the directed rows.
// Depends on lcdi_pkg and lcd_init_command_list_interpreter.
`timescale 1ns / 100ps

module tb_lcd_init_command_list_interpreter;
   import lcdi_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 285;
   localparam int SETTLE_CYCLES  = 6;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_CMD   = 3'd1,
      PH_ARGC  = 3'd2,
      PH_ARGS  = 3'd3,
      PH_DELAY = 3'd4
   } parse_phase_type;

   typedef struct {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] ms;
      logic        done;
   } display_op_type;

   typedef struct {
      item_type       item;
      bit             typed;
      bit             has_op;
      display_op_type op;
   } list_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_list_byte = 8'd0;
   logic        req_list_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic [15:0] rsp_wait_ms;
   logic        rsp_list_done;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   // shadow copy of the parser state and the long delay
   parse_phase_type phase_now = PH_IDLE;
   logic [7:0]      cmds_left = 8'd0;
   logic [6:0]      args_left = 7'd0;
   logic            delay_due = 1'b0;
   logic [15:0]     long_ms   = LONG_DELAY_RESET;

   display_op_type pending_ops[$];
   list_row_type   directed_rows[$];
   int             fail_count   = 0;
   int             parsed_count = 0;
   int             quiet_cycles = 0;
   bit             steady       = 1'b0;

   lcd_init_command_list_interpreter i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_list_byte  (req_list_byte),
      .req_list_start (req_list_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_wait_ms    (rsp_wait_ms),
      .rsp_list_done  (rsp_list_done),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int draw_wait();
      if (steady) return 0;
      return $urandom_range(0, 4);
   endfunction

   function automatic display_op_type make_op(kind_type k, logic [7:0] d, logic [15:0] ms,
                                              logic done);
      display_op_type op;
      op.kind = k;
      op.data = d;
      op.ms   = ms;
      op.done = done;
      return op;
   endfunction

   // close the current entry; 1 when it was the last of the list
   function automatic logic finish_entry();
      delay_due = 1'b0;
      args_left = 7'd0;
      if (cmds_left != 8'd0) begin
         phase_now = PH_CMD;
         return 1'b0;
      end
      phase_now = PH_IDLE;
      return 1'b1;
   endfunction

   task automatic parse_list_byte(input logic [7:0] b, input logic s, output bit got,
                                  output bit skipped, output display_op_type op);
      got     = 1'b0;
      skipped = !s && (phase_now == PH_IDLE);
      op      = make_op(KIND_CMD, 8'd0, 16'd0, 1'b0);
      if (s) begin
         cmds_left = b;
         args_left = 7'd0;
         delay_due = 1'b0;
         phase_now = (b != 8'd0) ? PH_CMD : PH_IDLE;
      end else begin
         case (phase_now)
            PH_CMD: begin
               cmds_left = cmds_left - 8'd1;
               phase_now = PH_ARGC;
               got       = 1'b1;
               op.data   = b;
            end
            PH_ARGC: begin
               args_left = b[6:0];
               delay_due = b[DELAY_FLAG_BIT];
               if (args_left != 7'd0) phase_now = PH_ARGS;
               else if (delay_due) phase_now = PH_DELAY;
               else op.done = finish_entry();
            end
            PH_ARGS: begin
               args_left = args_left - 7'd1;
               if (args_left == 7'd0) begin
                  if (delay_due) phase_now = PH_DELAY;
                  else op.done = finish_entry();
               end
               got     = 1'b1;
               op.kind = KIND_DATA;
               op.data = b;
            end
            PH_DELAY: begin
               op.ms   = (b == LONG_MARK) ? long_ms : {8'd0, b};
               op.done = finish_entry();
               op.kind = KIND_WAIT;
               got     = 1'b1;
            end
            default: phase_now = PH_IDLE;
         endcase
      end
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      fail_count++;
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   // present one transaction, hold it until accepted, then predict its result
   task automatic send_list_byte(input item_type it, input bit typed, input bit typed_has,
                                 input display_op_type typed_op);
      int             gap;
      bit             got;
      bit             skipped;
      display_op_type op;
      gap = draw_wait();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_list_byte  <= it.list_byte;
      req_list_start <= it.list_start;
      do @(posedge clock); while (!req_ready);
      parse_list_byte(it.list_byte, it.list_start, got, skipped, op);
      if (!skipped) parsed_count++;
      if (typed) begin
         got = typed_has;
         op  = typed_op;
      end
      if (got) pending_ops.push_back(op);
   endtask

   task automatic send_plain(input logic [7:0] b, input logic s);
      item_type it;
      it.list_byte  = b;
      it.list_start = s;
      send_list_byte(it, 1'b0, 1'b0, make_op(KIND_CMD, 8'd0, 16'd0, 1'b0));
   endtask

   // drop valid, let every expected result drain and the pipeline settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_ops.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_long_delay(input logic [15:0] v);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      long_ms = v;
   endtask

   task automatic add_row(input logic [7:0] b, input logic s, input bit typed,
                          input bit has_op, input kind_type k, input logic [7:0] d,
                          input logic [15:0] ms, input logic done);
      list_row_type row;
      row.item.list_byte  = b;
      row.item.list_start = s;
      row.typed           = typed;
      row.has_op          = has_op;
      row.op              = make_op(k, d, ms, done);
      directed_rows.push_back(row);
   endtask

   // one well-formed list with random content, now and then cut short or trailed by noise
   task automatic send_random_list();
      item_type   q[$];
      item_type   it;
      bit         broken;
      int         entries;
      int         nargs;
      int         cut;
      int         r;
      logic [7:0] count;
      bit         flag;
      broken = ($urandom_range(0, 9) == 0);
      if (broken) count = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 19) == 0) count = 8'd0;
      else count = 8'($urandom_range(1, 6));
      it.list_byte  = count;
      it.list_start = 1'b1;
      q.push_back(it);
      entries = broken ? $urandom_range(1, 3) : count;
      it.list_start = 1'b0;
      for (int e = 0; e < entries; e++) begin
         r = $urandom_range(0, 99);
         if (r < 70) nargs = $urandom_range(0, 3);
         else if (r < 97) nargs = $urandom_range(4, 15);
         else nargs = $urandom_range(16, 127);
         flag = 1'($urandom_range(0, 1));
         it.list_byte = 8'($urandom_range(0, 255));
         q.push_back(it);
         it.list_byte = {flag, 7'(nargs)};
         q.push_back(it);
         for (int a = 0; a < nargs; a++) begin
            it.list_byte = 8'($urandom_range(0, 255));
            q.push_back(it);
         end
         if (flag) begin
            it.list_byte = ($urandom_range(0, 3) == 0) ? LONG_MARK : 8'($urandom_range(0, 255));
            q.push_back(it);
         end
      end
      if (broken) begin
         cut = $urandom_range(1, q.size());
         while (q.size() > cut) it = q.pop_back();
      end
      if ($urandom_range(0, 4) == 0) begin
         it.list_start = 1'b0;
         repeat ($urandom_range(1, 3)) begin
            it.list_byte = 8'($urandom_range(0, 255));
            q.push_back(it);
         end
      end
      foreach (q[i]) send_plain(q[i].list_byte, q[i].list_start);
   endtask

   // result side: random stalls per result, compare against the oldest expectation
   initial begin
      int             stall;
      display_op_type want;
      wait (reset == 1'b0);
      forever begin
         stall = draw_wait();
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_ops.size() == 0) begin
            report_mismatch("result with none expected", 16'd0, {8'd0, rsp_out_byte});
         end else begin
            want = pending_ops.pop_front();
            if (rsp_out_kind !== want.kind)
               report_mismatch("out_kind", {14'd0, want.kind}, {14'd0, rsp_out_kind});
            if (rsp_out_byte !== want.data)
               report_mismatch("out_byte", {8'd0, want.data}, {8'd0, rsp_out_byte});
            if (rsp_wait_ms !== want.ms)
               report_mismatch("wait_ms", want.ms, rsp_wait_ms);
            if (rsp_list_done !== want.done)
               report_mismatch("list_done", {15'd0, want.done}, {15'd0, rsp_list_done});
         end
      end
   end

   // end the run once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [15:0] delay_settings[6];
      delay_settings[0] = 16'hFFFF;
      delay_settings[1] = 16'd0;
      delay_settings[2] = 16'd255;
      delay_settings[3] = 16'($urandom_range(0, 65535));
      delay_settings[4] = 16'd1;
      delay_settings[5] = LONG_DELAY_RESET;

      // bytes while idle, empty list, full list with every kind, mid-list restart
      add_row(8'h5A, 1'b0, 1'b1, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h00, 1'b1, 1'b1, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h11, 1'b0, 1'b1, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h03, 1'b1, 1'b1, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'hFF, 1'b0, 1'b1, 1'b1, KIND_CMD,  8'hFF, 16'd0,   1'b0);
      add_row(8'h82, 1'b0, 1'b1, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h00, 1'b0, 1'b1, 1'b1, KIND_DATA, 8'h00, 16'd0,   1'b0);
      add_row(8'hFF, 1'b0, 1'b1, 1'b1, KIND_DATA, 8'hFF, 16'd0,   1'b0);
      add_row(8'hFF, 1'b0, 1'b1, 1'b1, KIND_WAIT, 8'h00, 16'd500, 1'b0);
      add_row(8'h00, 1'b0, 1'b1, 1'b1, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h80, 1'b0, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h00, 1'b0, 1'b1, 1'b1, KIND_WAIT, 8'h00, 16'd0,   1'b0);
      add_row(8'h2C, 1'b0, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h01, 1'b0, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'hA5, 1'b0, 1'b1, 1'b1, KIND_DATA, 8'hA5, 16'd0,   1'b1);
      add_row(8'h01, 1'b1, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h29, 1'b0, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h00, 1'b0, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h44, 1'b0, 1'b1, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h02, 1'b1, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h01, 1'b0, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h01, 1'b1, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h36, 1'b0, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h81, 1'b0, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'h7E, 1'b0, 1'b0, 1'b0, KIND_CMD,  8'h00, 16'd0,   1'b0);
      add_row(8'hFE, 1'b0, 1'b1, 1'b1, KIND_WAIT, 8'h00, 16'd254, 1'b1);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_list_byte(directed_rows[i].item, directed_rows[i].typed,
                        directed_rows[i].has_op, directed_rows[i].op);

      for (int p = 0; p < 6; p++) begin
         set_long_delay(delay_settings[p]);
         steady       = (p == 3);
         parsed_count = 0;
         while (parsed_count < PHASE_ITEMS) begin
            send_random_list();
            // hold the sender until the result queue has run dry, after lists ending just past mid-phase
            if (p == 2 && parsed_count >= PHASE_ITEMS / 2 && parsed_count < PHASE_ITEMS / 2 + 40)
               wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

@@ lcd_init_command_list_interpreter.f @@
hdl/lcdi_pkg.sv
hdl/lcdi_in_stage.sv
hdl/lcdi_parser.sv
hdl/lcdi_out_stage.sv
hdl/lcd_init_command_list_interpreter.sv
hdl/lcdi_checker.sv
sim/tb_lcd_init_command_list_interpreter.sv
